/* hw/rtl/assert_macros.svh */
// Assertion shorthands for the lock table checkers.
// Each use expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge once reset is released
`define SELT_CHK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Same-cycle implication, antecedent and consequent given apart
`define SELT_CHK_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/selt_pkg.sv */
`default_nettype none

package selt_pkg;

  // Field widths of the transfers
  localparam int KIND_W = 3;
  localparam int TXN_W  = 4;
  localparam int VAR_W  = 5;
  localparam int MASK_W = 16;

  // Number of distinct variable indexes the request field can name
  localparam int VAR_SPAN = 1 << VAR_W;

  // Operation codes
  localparam logic [KIND_W-1:0] KIND_READ    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PROMOTE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RELTXN  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RELALL  = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TXN_W-1:0]  txn_id;
    logic [VAR_W-1:0]  var_index;
  } req_t;

  typedef struct packed {
    logic              granted;
    logic [MASK_W-1:0] holder_mask;
    logic [VAR_W-1:0]  released_var;
    logic              released_valid;
    logic              last;
  } rsp_t;

  // Table memory command group
  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic clr_all;
  } mem_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/selt_mem.sv */
`default_nettype none

// Lock table storage: one entry per variable, registered read port,
// one write port, and a live bit per entry so the whole table clears at once.
module selt_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5,
  parameter int RD_W  = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  selt_pkg::mem_ctl_t         ctl,
  input  logic [AW-1:0]              waddr,
  input  logic [RD_W-1:0]            w_readers,
  input  logic                       w_wvalid,
  input  logic [selt_pkg::TXN_W-1:0] w_owner,
  input  logic [AW-1:0]              raddr,
  output logic [RD_W-1:0]            r_readers,
  output logic                       r_wvalid,
  output logic [selt_pkg::TXN_W-1:0] r_owner
);
  import selt_pkg::*;

  logic [RD_W-1:0]  rdset_mem [DEPTH];
  logic             wv_mem    [DEPTH];
  logic [TXN_W-1:0] own_mem   [DEPTH];

  logic [DEPTH-1:0] live_r;
  logic             rd_live_r;
  logic [RD_W-1:0]  rd_rdset_r;
  logic             rd_wv_r;
  logic [TXN_W-1:0] rd_own_r;

  // Write port
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      rdset_mem[waddr] <= w_readers;
      wv_mem[waddr]    <= w_wvalid;
      own_mem[waddr]   <= w_owner;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_rdset_r <= rdset_mem[raddr];
      rd_wv_r    <= wv_mem[raddr];
      rd_own_r   <= own_mem[raddr];
      rd_live_r  <= live_r[raddr];
    end
  end

  // Entry live bits: an entry never written since the last clear reads as empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= '0;
    end else if (ctl.clr_all) begin
      live_r <= '0;
    end else if (ctl.wr_en) begin
      live_r[waddr] <= 1'b1;
    end
  end

  assign r_readers = rd_live_r ? rd_rdset_r : '0;
  assign r_wvalid  = rd_live_r & rd_wv_r;
  assign r_owner   = rd_live_r ? rd_own_r : '0;

endmodule

`default_nettype wire

/* hw/rtl/selt_ctrl.sv */
`default_nettype none

// Sequencer: read-modify-write of one entry per request, sweep of all
// entries for a transaction release, output register toward the consumer.
module selt_ctrl #(
  parameter int NUM_VARS = 32,
  parameter int NUM_TXNS = 16,
  parameter int DEPTH    = 32,
  parameter int AW       = 5,
  parameter int RD_W     = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  selt_pkg::req_t             in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output selt_pkg::rsp_t             out_data,
  output selt_pkg::mem_ctl_t         ctl,
  output logic [AW-1:0]              waddr,
  output logic [RD_W-1:0]            w_readers,
  output logic                       w_wvalid,
  output logic [selt_pkg::TXN_W-1:0] w_owner,
  output logic [AW-1:0]              raddr,
  input  logic [RD_W-1:0]            r_readers,
  input  logic                       r_wvalid,
  input  logic [selt_pkg::TXN_W-1:0] r_owner
);
  import selt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_WALK = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  state_t           state_r,    state_nxt;
  req_t             req_r,      req_nxt;
  logic [AW-1:0]    idx_r,      idx_nxt;
  logic             pend_v_r,   pend_v_nxt;
  logic [VAR_W-1:0] pend_var_r, pend_var_nxt;
  rsp_t             out_r,      out_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic             out_free;
  logic [RD_W-1:0]  tbit;
  logic             txn_ok;
  logic             var_ok;
  logic             hit;
  logic             emit;

  // Request path results
  rsp_t             ex_rsp;
  logic             ex_wr;
  logic             ex_clr;
  logic [RD_W-1:0]  ex_readers;
  logic             ex_wvalid;
  logic [TXN_W-1:0] ex_owner;

  function automatic logic var_fits(logic [VAR_W-1:0] v);
    return int'(v) < NUM_VARS;
  endfunction

  assign out_free = !out_valid_r || !out_stall;
  assign tbit     = RD_W'(1) << req_r.txn_id;
  assign txn_ok   = int'(req_r.txn_id) < NUM_TXNS;
  assign var_ok   = var_fits(req_r.var_index);
  assign hit      = r_wvalid && (r_owner == req_r.txn_id);
  assign emit     = hit && pend_v_r;

  // Single-entry update for read, write and promote; table clear for release-all
  always_comb begin
    ex_rsp      = '0;
    ex_rsp.last = 1'b1;
    ex_wr       = 1'b0;
    ex_clr      = 1'b0;
    ex_readers  = r_readers;
    ex_wvalid   = r_wvalid;
    ex_owner    = r_owner;
    case (req_r.kind)
      KIND_READ: begin
        if (txn_ok && var_ok) begin
          if (r_wvalid) begin
            ex_rsp.holder_mask = MASK_W'(1) << r_owner;
          end else begin
            ex_readers     = r_readers | tbit;
            ex_wr          = 1'b1;
            ex_rsp.granted = 1'b1;
          end
        end
      end
      KIND_WRITE: begin
        if (txn_ok && var_ok) begin
          if (r_readers != '0) begin
            ex_rsp.holder_mask = MASK_W'(r_readers);
          end else if (r_wvalid) begin
            ex_rsp.holder_mask = MASK_W'(1) << r_owner;
          end else begin
            ex_wvalid      = 1'b1;
            ex_owner       = req_r.txn_id;
            ex_wr          = 1'b1;
            ex_rsp.granted = 1'b1;
          end
        end
      end
      KIND_PROMOTE: begin
        if (txn_ok && var_ok) begin
          ex_readers     = '0;
          ex_wvalid      = 1'b1;
          ex_owner       = req_r.txn_id;
          ex_wr          = 1'b1;
          ex_rsp.granted = 1'b1;
        end
      end
      KIND_RELALL: begin
        ex_clr = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Sequencer and output register next state
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    idx_nxt       = idx_r;
    pend_v_nxt    = pend_v_r;
    pend_var_nxt  = pend_var_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    ctl           = '0;
    raddr         = '0;
    waddr         = idx_r;
    w_readers     = r_readers;
    w_wvalid      = r_wvalid;
    w_owner       = r_owner;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt    = in_data;
          ctl.rd_en  = 1'b1;
          if (in_data.kind == KIND_RELTXN) begin
            idx_nxt    = '0;
            pend_v_nxt = 1'b0;
            state_nxt  = S_WALK;
          end else begin
            if (var_fits(in_data.var_index)) begin
              raddr = in_data.var_index[AW-1:0];
            end
            state_nxt = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        if (out_free) begin
          ctl.wr_en     = ex_wr;
          ctl.clr_all   = ex_clr;
          waddr         = req_r.var_index[AW-1:0];
          w_readers     = ex_readers;
          w_wvalid      = ex_wvalid;
          w_owner       = ex_owner;
          out_nxt       = ex_rsp;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_WALK: begin
        // A freed lock is held back one step so the final one can carry last
        if (!emit || out_free) begin
          ctl.wr_en = 1'b1;
          w_readers = r_readers & ~tbit;
          w_wvalid  = r_wvalid & ~hit;
          w_owner   = hit ? '0 : r_owner;
          if (emit) begin
            out_nxt                = '0;
            out_nxt.released_var   = pend_var_r;
            out_nxt.released_valid = 1'b1;
            out_valid_nxt          = 1'b1;
          end
          if (hit) begin
            pend_v_nxt   = 1'b1;
            pend_var_nxt = VAR_W'(idx_r);
          end
          if (idx_r == LAST_IDX) begin
            state_nxt = S_FIN;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            ctl.rd_en = 1'b1;
            raddr     = idx_r + AW'(1);
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_nxt                = '0;
          out_nxt.released_var   = pend_v_r ? pend_var_r : '0;
          out_nxt.released_valid = pend_v_r;
          out_nxt.last           = 1'b1;
          out_valid_nxt          = 1'b1;
          state_nxt              = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pend_v_r    <= pend_v_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    idx_r      <= idx_nxt;
    pend_var_r <= pend_var_nxt;
    out_r      <= out_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

/* hw/rtl/shared_exclusive_lock_table.sv */
`default_nettype none

// Reader/writer lock table for NUM_VARS variables and NUM_TXNS transactions.
// Each variable's entry (reader set, writer flag, writer id) sits in one
// synchronous table memory. A read, write, promote, release-all or unknown
// operation reads the entry in S_IDLE, then updates it and loads the result
// register in S_EXEC, waiting there while the consumer stalls; no new transfer
// is taken until it is done. A transaction release sweeps every entry one per
// cycle through the same memory port, pausing when a result is due and the
// consumer stalls; it returns one transfer per freed write lock in ascending
// variable order, or a single transfer with released_valid low. The table is
// empty after reset and after release-all at once, with no clearing pass. Read,
// write and promote requests with a variable index at or above NUM_VARS or a
// transaction id at or above NUM_TXNS are refused without touching the table.
module shared_exclusive_lock_table #(
  parameter int NUM_VARS = 32,
  parameter int NUM_TXNS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  selt_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output selt_pkg::rsp_t out_data
);
  import selt_pkg::*;

  // Only variables the index field can name get an entry
  localparam int DEPTH = (NUM_VARS < VAR_SPAN) ? NUM_VARS : VAR_SPAN;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // Reader sets cover the valid transaction ids, up to the holder mask width
  localparam int RD_W  = (NUM_TXNS < MASK_W) ? NUM_TXNS : MASK_W;

  mem_ctl_t         ctl;
  logic [AW-1:0]    waddr;
  logic [AW-1:0]    raddr;
  logic [RD_W-1:0]  w_readers;
  logic             w_wvalid;
  logic [TXN_W-1:0] w_owner;
  logic [RD_W-1:0]  r_readers;
  logic             r_wvalid;
  logic [TXN_W-1:0] r_owner;

  selt_ctrl #(
    .NUM_VARS (NUM_VARS),
    .NUM_TXNS (NUM_TXNS),
    .DEPTH    (DEPTH),
    .AW       (AW),
    .RD_W     (RD_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .ctl       (ctl),
    .waddr     (waddr),
    .w_readers (w_readers),
    .w_wvalid  (w_wvalid),
    .w_owner   (w_owner),
    .raddr     (raddr),
    .r_readers (r_readers),
    .r_wvalid  (r_wvalid),
    .r_owner   (r_owner)
  );

  selt_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .RD_W  (RD_W)
  ) u_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .waddr     (waddr),
    .w_readers (w_readers),
    .w_wvalid  (w_wvalid),
    .w_owner   (w_owner),
    .raddr     (raddr),
    .r_readers (r_readers),
    .r_wvalid  (r_wvalid),
    .r_owner   (r_owner)
  );

endmodule

`default_nettype wire

/* hw/rtl/selt_checker.sv */
`default_nettype none

`include "assert_macros.svh"

// Port-level checks for the lock table
module selt_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input selt_pkg::req_t in_data,
  input logic           out_valid,
  input logic           out_stall,
  input selt_pkg::rsp_t out_data
);
  import selt_pkg::*;

  // Result transfer held while stalled
  `SELT_CHK(a_out_hold, (out_valid && out_stall |=> out_valid), "out_valid dropped under stall")
  `SELT_CHK(a_out_stable, (out_valid && out_stall |=> $stable(out_data)), "out_data moved under stall")

  // One operation at a time: the input side stalls right after a transfer
  `SELT_CHK(a_busy_after_take, (in_valid && !in_stall |=> in_stall), "second transfer taken while busy")

  // A new result only comes out of a busy cycle
  `SELT_CHK_IMPL(a_rsp_from_work, $rose(out_valid), $past(in_stall), "result without work")

  // Release results carry no grant and no blockers
  `SELT_CHK_IMPL(a_release_clean, out_valid && out_data.released_valid, !out_data.granted && out_data.holder_mask == '0, "release result mixes request fields")

endmodule

bind shared_exclusive_lock_table selt_checker u_selt_checker (.*);

`default_nettype wire
